@@ rtl/l4x_pkg.sv @@
package l4x_pkg;

    // Frame length bound: bytes at this position and beyond are dropped
    localparam int MAX_FRAME_BYTES = 65536;
    // Position counter wide enough to hold the bound itself
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    // Record queue between capture and record build (power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [5:0] LINK_HDR_RESET = 6'd14;

    // Byte offsets inside the IPv4 header
    localparam int OFF_VER_IHL = 0;
    localparam int OFF_PROTO = 9;
    localparam int OFF_SRC = 12;
    localparam int OFF_DST = 16;
    localparam int IP_MIN_HDR = 20;

    // Byte offsets inside the transport header
    localparam int T_SPORT = 0;
    localparam int T_DPORT = 2;
    localparam int T_FLAGS = 13;
    localparam int TCP_HDR_LEN = 20;
    localparam int UDP_HDR_LEN = 8;

    // IP protocol numbers
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    // Record status codes
    localparam logic [1:0] STATUS_SHORT_LINK = 2'd0;
    localparam logic [1:0] STATUS_SHORT_IP = 2'd1;
    localparam logic [1:0] STATUS_OK = 2'd2;

    // Protocol class codes
    localparam logic [1:0] CLASS_TCP = 2'd0;
    localparam logic [1:0] CLASS_UDP = 2'd1;
    localparam logic [1:0] CLASS_ICMP = 2'd2;
    localparam logic [1:0] CLASS_OTHER = 2'd3;

    // Captured fields of one finished frame
    typedef struct packed {
        logic [POS_W-1:0] count;
        logic [3:0]       ihl;
        logic [7:0]       protocol;
        logic [31:0]      src;
        logic [31:0]      dst;
        logic [15:0]      sport;
        logic [15:0]      dport;
        logic [4:0]       flags;
    } l4x_frame_t;

endpackage

@@ rtl/l4x_front.sv @@
module l4x_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [5:0]           lhb,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           byte_value,
    input  logic                 last_byte,
    input  logic                 q_full,
    output logic                 push,
    output l4x_pkg::l4x_frame_t  push_rec
);

    localparam int PW = l4x_pkg::POS_W;

    logic [PW-1:0] pos_reg;
    logic [3:0]    ihl_reg;
    logic [7:0]    proto_reg;
    logic [31:0]   src_reg;
    logic [31:0]   dst_reg;
    logic [15:0]   sport_reg;
    logic [15:0]   dport_reg;
    logic [4:0]    flags_reg;

    logic [PW-1:0] pos_next;
    logic [3:0]    ihl_next;
    logic [7:0]    proto_next;
    logic [31:0]   src_next;
    logic [31:0]   dst_next;
    logic [15:0]   sport_next;
    logic [15:0]   dport_next;
    logic [4:0]    flags_next;

    logic          accept;
    logic          in_window;
    logic          ip_hit;
    logic          l4_hit;
    logic [PW-1:0] off;
    logic [PW-1:0] toff;
    logic [5:0]    hb;

    // Stall the byte stream only when the record queue has no room
    assign in_stall = q_full;
    assign accept = in_valid && !in_stall;
    assign push = accept && last_byte;

    // Locate the byte inside the IPv4 and transport headers
    always_comb
    begin
        in_window = pos_reg < PW'(l4x_pkg::MAX_FRAME_BYTES);
        ip_hit = in_window && (pos_reg >= PW'(lhb));
        off = pos_reg - PW'(lhb);
        hb = {ihl_reg, 2'b00};
        l4_hit = ip_hit && (hb >= 6'(l4x_pkg::IP_MIN_HDR)) && (off >= PW'(hb));
        toff = off - PW'(hb);
    end

    // Capture header fields by position
    always_comb
    begin
        pos_next = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
        ihl_next = ihl_reg;
        proto_next = proto_reg;
        src_next = src_reg;
        dst_next = dst_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        flags_next = flags_reg;
        if (ip_hit)
        begin
            if (off == PW'(l4x_pkg::OFF_VER_IHL))
                ihl_next = byte_value[3:0];
            else if (off == PW'(l4x_pkg::OFF_PROTO))
                proto_next = byte_value;
            else if (off >= PW'(l4x_pkg::OFF_SRC) && off < PW'(l4x_pkg::OFF_DST))
                src_next = {src_reg[23:0], byte_value};
            else if (off >= PW'(l4x_pkg::OFF_DST) && off < PW'(l4x_pkg::IP_MIN_HDR))
                dst_next = {dst_reg[23:0], byte_value};
        end
        if (l4_hit)
        begin
            if (toff == PW'(l4x_pkg::T_SPORT) || toff == PW'(l4x_pkg::T_SPORT + 1))
                sport_next = {sport_reg[7:0], byte_value};
            else if (toff == PW'(l4x_pkg::T_DPORT) || toff == PW'(l4x_pkg::T_DPORT + 1))
                dport_next = {dport_reg[7:0], byte_value};
            else if (toff == PW'(l4x_pkg::T_FLAGS))
                // wire order FIN SYN RST PSH ACK -> SYN ACK FIN RST PSH
                flags_next = {byte_value[3], byte_value[2], byte_value[0],
                              byte_value[4], byte_value[1]};
        end
    end

    // Hand the finished frame to the queue
    always_comb
    begin
        push_rec.count = pos_next;
        push_rec.ihl = ihl_next;
        push_rec.protocol = proto_next;
        push_rec.src = src_next;
        push_rec.dst = dst_next;
        push_rec.sport = sport_next;
        push_rec.dport = dport_next;
        push_rec.flags = flags_next;
    end

    // Advance frame state; clear it after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ihl_reg <= '0;
            proto_reg <= '0;
            src_reg <= '0;
            dst_reg <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
            flags_reg <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg <= '0;
                ihl_reg <= '0;
                proto_reg <= '0;
                src_reg <= '0;
                dst_reg <= '0;
                sport_reg <= '0;
                dport_reg <= '0;
                flags_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_next;
                ihl_reg <= ihl_next;
                proto_reg <= proto_next;
                src_reg <= src_next;
                dst_reg <= dst_next;
                sport_reg <= sport_next;
                dport_reg <= dport_next;
                flags_reg <= flags_next;
            end
        end
    end

    // A final byte leaves a fresh frame behind
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (pos_reg == '0 && ihl_reg == '0))
        else $error("frame state not cleared after final byte");

endmodule

@@ rtl/l4x_queue.sv @@
module l4x_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  l4x_pkg::l4x_frame_t  push_rec,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output l4x_pkg::l4x_frame_t  head_rec
);

    localparam int PW = l4x_pkg::PTR_W;

    l4x_pkg::l4x_frame_t entry_reg [l4x_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic [PW:0]   count_next;

    assign full = (count_reg == (PW+1)'(l4x_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec = entry_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Store records
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("record pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("record popped from empty queue");

endmodule

@@ rtl/l4x_back.sv @@
module l4x_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [5:0]           lhb,
    input  logic                 head_valid,
    input  l4x_pkg::l4x_frame_t  head_rec,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [7:0]           protocol,
    output logic [1:0]           proto_class,
    output logic [31:0]          src_addr,
    output logic [31:0]          dest_addr,
    output logic                 ports_valid,
    output logic [15:0]          src_port,
    output logic [15:0]          dst_port,
    output logic [4:0]           tcp_flags,
    output logic [15:0]          ip_length,
    output logic [5:0]           header_bytes
);

    localparam int PW = l4x_pkg::POS_W;

    logic          out_valid_reg;
    logic [1:0]    status_reg,   status_next;
    logic [7:0]    protocol_reg, protocol_next;
    logic [1:0]    class_reg,    class_next;
    logic [31:0]   src_reg,      src_next;
    logic [31:0]   dst_reg,      dst_next;
    logic          pv_reg,       pv_next;
    logic [15:0]   sport_reg,    sport_next;
    logic [15:0]   dport_reg,    dport_next;
    logic [4:0]    flags_reg,    flags_next;
    logic [15:0]   iplen_reg,    iplen_next;
    logic [5:0]    hb_reg,       hb_next;

    logic [PW-1:0] eff;
    logic [PW-1:0] iplen_w;
    logic [31:0]   iplen32;
    logic [15:0]   iplen;
    logic          link_short;
    logic          ip_short;
    logic [1:0]    cls;
    logic [5:0]    hb;
    logic          pv;

    // Take the head record when the output register is free or drains
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    // Work out lengths and protocol class
    always_comb
    begin
        eff = (head_rec.count >= PW'(l4x_pkg::MAX_FRAME_BYTES))
            ? PW'(l4x_pkg::MAX_FRAME_BYTES) : head_rec.count;
        link_short = eff <= PW'(lhb);
        iplen_w = eff - PW'(lhb);
        iplen32 = 32'(iplen_w);
        iplen = (iplen32 > 32'hFFFF) ? 16'hFFFF : iplen32[15:0];
        ip_short = iplen < 16'(l4x_pkg::IP_MIN_HDR);
        hb = {head_rec.ihl, 2'b00};
        case (head_rec.protocol)
            l4x_pkg::PROTO_TCP:  cls = l4x_pkg::CLASS_TCP;
            l4x_pkg::PROTO_UDP:  cls = l4x_pkg::CLASS_UDP;
            l4x_pkg::PROTO_ICMP: cls = l4x_pkg::CLASS_ICMP;
            default:             cls = l4x_pkg::CLASS_OTHER;
        endcase
        pv = (hb >= 6'(l4x_pkg::IP_MIN_HDR)) &&
             (((cls == l4x_pkg::CLASS_TCP) &&
               (17'(iplen) >= 17'(hb) + 17'(l4x_pkg::TCP_HDR_LEN))) ||
              ((cls == l4x_pkg::CLASS_UDP) &&
               (17'(iplen) >= 17'(hb) + 17'(l4x_pkg::UDP_HDR_LEN))));
    end

    // Build the record, zeroing fields that the status does not cover
    always_comb
    begin
        status_next = l4x_pkg::STATUS_OK;
        protocol_next = head_rec.protocol;
        class_next = cls;
        src_next = head_rec.src;
        dst_next = head_rec.dst;
        pv_next = pv;
        sport_next = pv ? head_rec.sport : 16'd0;
        dport_next = pv ? head_rec.dport : 16'd0;
        flags_next = (pv && cls == l4x_pkg::CLASS_TCP) ? head_rec.flags : 5'd0;
        iplen_next = iplen;
        hb_next = hb;
        if (link_short || ip_short)
        begin
            status_next = link_short ? l4x_pkg::STATUS_SHORT_LINK
                                     : l4x_pkg::STATUS_SHORT_IP;
            protocol_next = '0;
            class_next = '0;
            src_next = '0;
            dst_next = '0;
            pv_next = 1'b0;
            sport_next = '0;
            dport_next = '0;
            flags_next = '0;
            iplen_next = link_short ? 16'd0 : iplen;
            hb_next = '0;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            protocol_reg <= protocol_next;
            class_reg <= class_next;
            src_reg <= src_next;
            dst_reg <= dst_next;
            pv_reg <= pv_next;
            sport_reg <= sport_next;
            dport_reg <= dport_next;
            flags_reg <= flags_next;
            iplen_reg <= iplen_next;
            hb_reg <= hb_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign protocol = protocol_reg;
    assign proto_class = class_reg;
    assign src_addr = src_reg;
    assign dest_addr = dst_reg;
    assign ports_valid = pv_reg;
    assign src_port = sport_reg;
    assign dst_port = dport_reg;
    assign tcp_flags = flags_reg;
    assign ip_length = iplen_reg;
    assign header_bytes = hb_reg;

    a_ports_need_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pv_reg) |-> (status_reg == l4x_pkg::STATUS_OK &&
            (class_reg == l4x_pkg::CLASS_TCP || class_reg == l4x_pkg::CLASS_UDP)))
        else $error("ports reported without a complete transport header");

    a_flags_tcp_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && flags_reg != 5'd0) |-> (pv_reg && class_reg == l4x_pkg::CLASS_TCP))
        else $error("TCP flags reported for a non-TCP record");

endmodule

@@ rtl/ipv4_l4_header_extractor_top.sv @@
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   byte_value, last_byte
// out       output     out_valid / out_stall status ... header_bytes (one record)
// cfg       input      cfg_valid / cfg_ready cfg_data (link header bytes)
//
// Takes one byte per cycle unless stalled; records are queued, then registered.
// A four-entry record queue sits between byte capture and record build, so in_stall
// rises only when four records wait behind a stalled output.
// Reset clears frame state and sets the link header length to 14; no clearing pass.
// cfg_ready is always high; write it only while no frame is in flight.
module ipv4_l4_header_extractor_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  protocol,
    output logic [1:0]  proto_class,
    output logic [31:0] src_addr,
    output logic [31:0] dest_addr,
    output logic        ports_valid,
    output logic [15:0] src_port,
    output logic [15:0] dst_port,
    output logic [4:0]  tcp_flags,
    output logic [15:0] ip_length,
    output logic [5:0]  header_bytes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    logic [5:0]           lhb_reg;
    logic                 q_full;
    logic                 push;
    l4x_pkg::l4x_frame_t  push_rec;
    logic                 pop;
    logic                 head_valid;
    l4x_pkg::l4x_frame_t  head_rec;

    // Hold the link header length register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lhb_reg <= l4x_pkg::LINK_HDR_RESET;
        else if (cfg_valid && cfg_ready)
            lhb_reg <= cfg_data;
    end

    l4x_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .lhb        (lhb_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_value (byte_value),
        .last_byte  (last_byte),
        .q_full     (q_full),
        .push       (push),
        .push_rec   (push_rec)
    );

    l4x_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    l4x_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .lhb          (lhb_reg),
        .head_valid   (head_valid),
        .head_rec     (head_rec),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .protocol     (protocol),
        .proto_class  (proto_class),
        .src_addr     (src_addr),
        .dest_addr    (dest_addr),
        .ports_valid  (ports_valid),
        .src_port     (src_port),
        .dst_port     (dst_port),
        .tcp_flags    (tcp_flags),
        .ip_length    (ip_length),
        .header_bytes (header_bytes)
    );

endmodule
